// ===== hdl/isq_pkg.sv =====
// shared types, constants and helpers for the indexed sequence store
package isq_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_BITS  = 32;

  localparam int POS_W      = 7;   // position and element_count field width
  localparam int DATA_W     = 32;  // data_word and read_word field width
  localparam int STAT_W     = 2;

  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 en;
    op_t                  op;
    logic [POS_W-1:0]     pos;
    logic [WORD_BITS-1:0] word;
  } cell_ctrl_t;

  // sign-extend (or truncate) a stored element to the read_word field
  function automatic logic [DATA_W-1:0] widen_word(input logic [WORD_BITS-1:0] w);
    logic signed [WORD_BITS-1:0] s;
    s = signed'(w);
    return DATA_W'(s);
  endfunction

endpackage

// ===== hdl/isq_cell.sv =====
// one storage cell of the element chain
module isq_cell (
  input  logic                          clk,
  input  isq_pkg::cell_ctrl_t           ctrl,
  input  logic [isq_pkg::IDX_W-1:0]     index,
  input  logic [isq_pkg::WORD_BITS-1:0] left_word,
  input  logic [isq_pkg::WORD_BITS-1:0] right_word,
  output logic [isq_pkg::WORD_BITS-1:0] word,
  output logic [isq_pkg::WORD_BITS-1:0] tap_word
);
  import isq_pkg::*;

  logic [CMP_W-1:0]     idx_c;
  logic [CMP_W-1:0]     pos_c;
  logic                 at_pos;
  logic                 above_pos;
  logic [WORD_BITS-1:0] word_next;

  assign idx_c     = CMP_W'(index);
  assign pos_c     = CMP_W'(ctrl.pos);
  assign at_pos    = (idx_c == pos_c);
  assign above_pos = (idx_c > pos_c);

  always_comb begin
    word_next = word;
    case (ctrl.op)
      OP_INSERT: begin
        if (above_pos) begin
          word_next = left_word;
        end else if (at_pos) begin
          word_next = ctrl.word;
        end
      end
      OP_ERASE: begin
        if (at_pos || above_pos) begin
          word_next = right_word;
        end
      end
      OP_SET: begin
        if (at_pos) begin
          word_next = ctrl.word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      word <= word_next;
    end
  end

  // only the addressed cell drives its tap, the rest read as zero
  assign tap_word = at_pos ? word : '0;

endmodule

// ===== hdl/indexed_sequence_store.sv =====
// top level: ordered element store built from a chain of shift cells
//
//  port group   dir  handshake            payload
//  request      in   in_valid / in_ready  req_type, position, data_word
//  result       out  out_valid/out_ready  read_word, element_count, status
//
// each word goes through accept, execute (all cells shift or load at once),
// gather (registered or-tree of the cell taps into the result register)
// a new request is taken only once the previous result is in the output reg
// a stalled result holds in the output register; the next request may be
// accepted and executed meanwhile, and waits in gather until the slot frees
// rst clears the control state and the count; cell contents are not reset
module indexed_sequence_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [isq_pkg::POS_W-1:0]    position,
  input  logic signed [isq_pkg::DATA_W-1:0] data_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [isq_pkg::DATA_W-1:0] read_word,
  output logic [isq_pkg::POS_W-1:0]    element_count,
  output logic [isq_pkg::STAT_W-1:0]   status
);
  import isq_pkg::*;

  // control
  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_load;

  // captured request
  op_t                  req_op;
  logic [POS_W-1:0]     req_pos;
  logic [WORD_BITS-1:0] req_word;

  // element count and execute-stage decode
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   cnt_c;
  status_t            exec_st;
  status_t            res_st;

  cell_ctrl_t ctrl;

  // cell chain
  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic [WORD_BITS-1:0] cell_tap  [CAPACITY];

  // read gather tree
  logic [WORD_BITS-1:0] group_or      [NUM_GROUPS];
  logic [WORD_BITS-1:0] group_reg     [NUM_GROUPS];
  logic [WORD_BITS-1:0] gathered_word;

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_GATHER;
      end
      S_GATHER: begin
        // result slot free, or being emptied this cycle
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= op_t'(req_type);
      req_pos  <= position;
      req_word <= WORD_BITS'(data_word);
    end
  end

  // ---------------------------------------------------------------- execute
  assign pos_c = CMP_W'(req_pos);
  assign cnt_c = CMP_W'(count);

  always_comb begin
    exec_st    = ST_OK;
    count_next = count;
    if (req_op == OP_INSERT) begin
      // past-the-end check comes before the full check
      if (pos_c > cnt_c) begin
        exec_st = ST_RANGE;
      end else if (count == COUNT_W'(CAPACITY)) begin
        exec_st = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (pos_c >= cnt_c) begin
      exec_st = ST_RANGE;
    end else if (req_op == OP_ERASE) begin
      count_next = count - 1'b1;
    end
  end

  assign ctrl.en   = (state == S_EXEC) && (exec_st == ST_OK);
  assign ctrl.op   = req_op;
  assign ctrl.pos  = req_pos;
  assign ctrl.word = req_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_EXEC) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_st <= exec_st;
    end
  end

  // ---------------------------------------------------------------- cells
  // cell i takes cell i-1 on insert and cell i+1 on erase; the ends see zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_in;
    logic [WORD_BITS-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_word[i+1];
    end

    isq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (IDX_W'(i)),
      .left_word  (left_in),
      .right_word (right_in),
      .word       (cell_word[i]),
      .tap_word   (cell_tap[i])
    );
  end

  // ---------------------------------------------------------------- gather
  // first level: or of each group of taps, registered in the execute cycle
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_or[g] = group_or[g] | cell_tap[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        group_reg[g] <= group_or[g];
      end
    end
  end

  // second level: or of the group registers
  always_comb begin
    gathered_word = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gathered_word = gathered_word | group_reg[g];
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      // read data only for a successful get
      if (req_op == OP_GET && res_st == ST_OK) begin
        read_word <= widen_word(gathered_word);
      end else begin
        read_word <= '0;
      end
      element_count <= POS_W'(count);
      status        <= res_st;
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted word did not enter execute");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && req_op == OP_INSERT && exec_st == ST_OK)
      |=> count == $past(count) + 1'b1)
    else $error("successful insert did not grow the count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && exec_st == ST_FULL) |-> count == COUNT_W'(CAPACITY))
    else $error("full status with room left");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

// ===== sim/indexed_sequence_store_checker.sv =====
// result checker for the indexed sequence store: tracks requests and scores results
`timescale 1ns / 1ps

module indexed_sequence_store_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic [isq_pkg::POS_W-1:0]         position,
  input  logic signed [isq_pkg::DATA_W-1:0] data_word,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [isq_pkg::DATA_W-1:0] read_word,
  input  logic [isq_pkg::POS_W-1:0]         element_count,
  input  logic [isq_pkg::STAT_W-1:0]        status,
  output int                                fail_count,
  output int                                outstanding
);
  import isq_pkg::*;

  typedef struct {
    op_t                     op;
    logic [POS_W-1:0]        pos;
    logic signed [DATA_W-1:0] read_word;
    logic [POS_W-1:0]        count;
    status_t                 status;
  } seq_result_t;

  // shadow of the store contents and length
  logic [WORD_BITS-1:0] seq_mem [CAPACITY];
  int                   seq_len;

  seq_result_t pending_results [$];
  int          fails;

  initial begin
    seq_len     = 0;
    fails       = 0;
    fail_count  = 0;
    outstanding = 0;
  end

  // applies one word to the shadow store and returns the result it should give
  function automatic seq_result_t apply_request(op_t op, logic [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] data);
    seq_result_t          r;
    logic [WORD_BITS-1:0] w;
    r.op        = op;
    r.pos       = pos;
    r.read_word = '0;
    r.status    = ST_OK;
    w           = data[WORD_BITS-1:0];
    if (op == OP_INSERT) begin
      if (pos > seq_len) begin
        r.status = ST_RANGE;
      end else if (seq_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int i = seq_len; i > pos; i--) seq_mem[i] = seq_mem[i-1];
        seq_mem[pos] = w;
        seq_len++;
      end
    end else if (pos >= seq_len) begin
      r.status = ST_RANGE;
    end else if (op == OP_ERASE) begin
      for (int i = pos; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i+1];
      seq_len--;
    end else if (op == OP_GET) begin
      r.read_word = DATA_W'(signed'(seq_mem[pos]));
    end else begin
      seq_mem[pos] = w;
    end
    r.count = POS_W'(seq_len);
    return r;
  endfunction

  always @(posedge clk) begin
    seq_result_t exp_r;
    if (!rst) begin
      // score the result first: no word can come back at its own accept edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word: read %h count %0d status %0d",
                     read_word, element_count, status);
        end else begin
          exp_r = pending_results.pop_front();
          if (read_word !== exp_r.read_word || element_count !== exp_r.count ||
              status !== exp_r.status) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch on %s pos %0d: expected read %h count %0d status %0d,",
                        " got read %h count %0d status %0d"},
                       exp_r.op.name(), exp_r.pos, exp_r.read_word, exp_r.count,
                       exp_r.status, read_word, element_count, status);
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_request(op_t'(req_type), position, data_word));
    end
    fail_count  <= fails;
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/indexed_sequence_store_tb.sv =====
// testbench top for the indexed sequence store: stimulus, flow control and verdict
`timescale 1ns / 1ps

module indexed_sequence_store_tb;
  import isq_pkg::*;

  localparam int RANDOM_BLOCKS = 11;      // blocks of random words
  localparam int BLOCK_WORDS   = 100;
  localparam int LONG_HOLD     = 300;     // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES  = 20;      // settle time after the last result
  localparam int CYCLE_LIMIT   = 400000;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_word;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] read_word;
  logic [POS_W-1:0]         element_count;
  logic [STAT_W-1:0]        status;

  int fail_count;
  int outstanding;
  int cycle_count;

  // sender bookkeeping
  int burst_left;
  bit valid_held;
  int shadow_len;   // length the store will have once all offered words land

  indexed_sequence_store DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .position      (position),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_word     (read_word),
    .element_count (element_count),
    .status        (status)
  );

  indexed_sequence_store_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .position      (position),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_word     (read_word),
    .element_count (element_count),
    .status        (status),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one request word and hold it until the block takes it; between bursts
  // the sender drops valid for a random gap
  task automatic push_request(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] data);
    int gap;
    in_valid   <= 1'b1;
    req_type   <= op;
    position   <= pos;
    data_word  <= data;
    valid_held = 1'b1;
    // the length only moves on a request that succeeds
    if (op == OP_INSERT && pos <= shadow_len && shadow_len < CAPACITY) shadow_len++;
    else if (op == OP_ERASE && pos < shadow_len) shadow_len--;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // receiver: segments of random stall patterns, with two long hold-offs that
  // let the block back up and stall its input while the sender keeps offering
  initial begin
    int seg;
    int seg_len;
    int mode;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    for (seg = 0; ; seg++) begin
      if (seg == 25 || seg == 90) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        case (mode)
          0:       out_ready <= 1'b1;                          // no stalls
          1:       out_ready <= ($urandom_range(0, 1) == 1);   // half the time
          2:       out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_ready <= ($urandom_range(0, 7) != 0);   // rare stalls
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int   blk;
    int   n;
    int   r;
    int   w_ins;
    int   w_era;
    op_t  op;
    logic [POS_W-1:0] pos;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= OP_GET;
    position   <= '0;
    data_word  <= '0;
    burst_left = 0;
    valid_held = 1'b0;
    shadow_len = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every access on an empty store is out of range
    push_request(OP_GET,    7'd0,  32'd0);
    push_request(OP_ERASE,  7'd0,  32'd0);
    push_request(OP_SET,    7'd0,  32'h1234_5678);
    // insert past the end, including the top position
    push_request(OP_INSERT, 7'd1,  32'h0000_0001);
    push_request(OP_INSERT, 7'd64, 32'h0000_0002);
    // build a short list: first word, append, front, middle; data extremes
    push_request(OP_INSERT, 7'd0,  32'h8000_0000);
    push_request(OP_INSERT, 7'd1,  32'h7fff_ffff);
    push_request(OP_INSERT, 7'd0,  32'h0000_0000);
    push_request(OP_INSERT, 7'd1,  32'hffff_ffff);
    for (n = 0; n < 4; n++) push_request(OP_GET, POS_W'(n), 32'hdead_beef);
    // get one past the last element
    push_request(OP_GET,    7'd4,  32'd0);
    push_request(OP_SET,    7'd2,  32'h5555_5555);
    push_request(OP_SET,    7'd3,  32'haaaa_aaaa);
    push_request(OP_GET,    7'd2,  32'd0);
    // erase first and last, then out of range at the top position
    push_request(OP_ERASE,  7'd0,  32'd0);
    push_request(OP_ERASE,  7'd2,  32'd0);
    push_request(OP_GET,    7'd1,  32'd0);
    push_request(OP_ERASE,  7'd64, 32'd0);
    // append at the count, then erase from the middle
    push_request(OP_INSERT, 7'd2,  32'h0000_0001);
    push_request(OP_ERASE,  7'd1,  32'd0);
    push_request(OP_GET,    7'd0,  32'd0);
    push_request(OP_GET,    7'd1,  32'd0);

    // random: blocks alternate between filling, mixed use and draining so the
    // store passes through empty, mid-size and full (where inserts bounce)
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk % 4)
        0:       begin w_ins = 70; w_era = 10; end   // fill
        2:       begin w_ins = 10; w_era = 65; end   // drain
        default: begin w_ins = 35; w_era = 25; end   // mixed, slight upward drift
      endcase
      for (n = 0; n < BLOCK_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < w_ins) op = OP_INSERT;
        else if (r < w_ins + w_era) op = OP_ERASE;
        else if (r < w_ins + w_era + (100 - w_ins - w_era) / 2) op = OP_GET;
        else op = OP_SET;
        // mostly legal positions, some anywhere from zero up to the capacity
        if ($urandom_range(0, 99) < 15)
          pos = POS_W'($urandom_range(0, CAPACITY));
        else if (op == OP_INSERT)
          pos = POS_W'($urandom_range(0, shadow_len));
        else if (shadow_len > 0)
          pos = POS_W'($urandom_range(0, shadow_len - 1));
        else
          pos = '0;
        push_request(op, pos, $urandom);
      end
    end

    if (valid_held) in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
